// ===== src/nns_pkg.sv =====
// Shared types and codes for the nearest neighbor search unit.
package nns_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam int DIST_W      = 48;
   localparam int SQUARE_W    = 34;

   localparam logic [1:0] CMD_LOAD_REF   = 2'd0;
   localparam logic [1:0] CMD_LOAD_LABEL = 2'd1;
   localparam logic [1:0] CMD_QUERY      = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FACE_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMP_COUNT = 1'd1;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         face_index;
      logic [5:0]         component_index;
      logic signed [15:0] coeff_value;
      logic [7:0]         label_value;
      logic               query_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0]        nearest_index;
      logic [7:0]        nearest_label;
      logic [DIST_W-1:0] best_distance;
   } rsp_word_type;

   typedef struct packed {
      logic ref_we;
      logic query_we;
      logic label_we;
   } store_we_type;

   typedef struct packed {
      logic valid;
      logic first_comp;
      logic last_comp;
      logic first_face;
   } scan_tag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_LABEL,
      ST_RESULT
   } scan_state_type;

endpackage

// ===== src/nns_store.sv =====
// Reference, query and label memories with registered read data.
module nns_store #(
   parameter int FACE_W = 8,
   parameter int COMP_W = 6,
   parameter int REF_AW = 14
) (
   input  logic                  clock,
   input  nns_pkg::store_we_type we,
   input  logic [REF_AW-1:0]     ref_waddr,
   input  logic [COMP_W-1:0]     query_waddr,
   input  logic [FACE_W-1:0]     label_waddr,
   input  logic [15:0]           coeff_wdata,
   input  logic [7:0]            label_wdata,
   input  logic [REF_AW-1:0]     ref_raddr,
   input  logic [COMP_W-1:0]     query_raddr,
   input  logic [FACE_W-1:0]     label_raddr,
   output logic [15:0]           ref_rdata,
   output logic [15:0]           query_rdata,
   output logic [7:0]            label_rdata
);

   localparam int REF_DEPTH   = 2 ** REF_AW;
   localparam int QUERY_DEPTH = 2 ** COMP_W;
   localparam int LABEL_DEPTH = 2 ** FACE_W;

   logic [15:0] ref_mem   [REF_DEPTH];
   logic [15:0] query_mem [QUERY_DEPTH];
   logic [7:0]  label_mem [LABEL_DEPTH];

   logic [15:0] ref_rdata_ff;
   logic [15:0] query_rdata_ff;
   logic [7:0]  label_rdata_ff;

   always_ff @(posedge clock) begin
      if (we.ref_we) begin
         ref_mem[ref_waddr] <= coeff_wdata;
      end
      ref_rdata_ff <= ref_mem[ref_raddr];
   end

   always_ff @(posedge clock) begin
      if (we.query_we) begin
         query_mem[query_waddr] <= coeff_wdata;
      end
      query_rdata_ff <= query_mem[query_raddr];
   end

   always_ff @(posedge clock) begin
      if (we.label_we) begin
         label_mem[label_waddr] <= label_wdata;
      end
      label_rdata_ff <= label_mem[label_raddr];
   end

   assign ref_rdata   = ref_rdata_ff;
   assign query_rdata = query_rdata_ff;
   assign label_rdata = label_rdata_ff;

endmodule

// ===== src/nns_dist.sv =====
// Squared difference, saturating accumulation and running minimum pipeline.
module nns_dist #(
   parameter int FACE_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  nns_pkg::scan_tag_type      tag,
   input  logic [FACE_W-1:0]          face,
   input  logic [15:0]                ref_rdata,
   input  logic [15:0]                query_rdata,
   output logic [FACE_W-1:0]          best_face,
   output logic [nns_pkg::DIST_W-1:0] best_dist
);

   nns_pkg::scan_tag_type s1_tag_ff, s2_tag_ff, s3_tag_ff;
   logic [FACE_W-1:0] s1_face_ff, s2_face_ff, s3_face_ff;

   logic signed [16:0]               diff;
   logic [16:0]                      mag;
   logic [nns_pkg::SQUARE_W-1:0]     sq_in, sq_ff;
   logic [nns_pkg::DIST_W:0]         sum_wide;
   logic [nns_pkg::DIST_W-1:0]       acc_in, acc_ff;
   logic                             take_best;
   logic [nns_pkg::DIST_W-1:0]       best_dist_ff;
   logic [FACE_W-1:0]                best_face_ff;

   always_comb begin
      diff  = {query_rdata[15], query_rdata} - {ref_rdata[15], ref_rdata};
      mag   = diff[16] ? 17'(-diff) : 17'(diff);
      sq_in = nns_pkg::SQUARE_W'(mag * mag);
   end

   always_comb begin
      sum_wide = {1'b0, acc_ff} + (nns_pkg::DIST_W + 1)'(sq_ff);
      if (s2_tag_ff.first_comp) begin
         acc_in = nns_pkg::DIST_W'(sq_ff);
      end else if (sum_wide[nns_pkg::DIST_W]) begin
         acc_in = '1;
      end else begin
         acc_in = sum_wide[nns_pkg::DIST_W-1:0];
      end
   end

   assign take_best = s3_tag_ff.valid && s3_tag_ff.last_comp &&
                      (s3_tag_ff.first_face || (acc_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else begin
         s1_tag_ff <= tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_face_ff <= face;
      s2_face_ff <= s1_face_ff;
      s3_face_ff <= s2_face_ff;
      sq_ff      <= sq_in;
      if (s2_tag_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (take_best) begin
         best_dist_ff <= acc_ff;
         best_face_ff <= s3_face_ff;
      end
   end

   assign best_face = best_face_ff;
   assign best_dist = best_dist_ff;

endmodule

// ===== src/nearest_neighbor_search_unit.sv =====
// Top level of the nearest neighbor search unit: command decode, scan sequencer, result word.
//
// The req_ channel carries one word per item: a reference coefficient load, a
// label load or a query coefficient. Outside a scan, load and query words are taken one per
// cycle. A query word with query_last set starts a scan over the first
// face_count reference vectors, each over its first component_count
// coefficients, read from the reference memory one coefficient per cycle.
// After the last query word is taken and the scan has run, the result word appears
// on the rsp_ channel through the registered memory read, the square, the accumulate,
// the minimum update, the label read and the output register.
// req_stall is high while the scan and its result steps run. A result word that
// the receiver stalls is held in the output register; load words are still taken
// meanwhile, and only a new query_last word waits until the result word has gone.
// The csr_ port writes face_count (index 0) and component_count (index 1); write them
// only while the block is idle, which it does not enforce. Reset returns both counts to
// one and empties the output register; memory contents are kept, valid only once written.
module nearest_neighbor_search_unit #(
   parameter int MAX_FACES      = 256,
   parameter int MAX_COMPONENTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nns_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nns_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_write,
   input  logic [nns_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nns_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int FACE_W = $clog2(MAX_FACES);
   localparam int COMP_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
   localparam int REF_AW = $clog2(MAX_FACES * MAX_COMPONENTS);

   nns_pkg::scan_state_type state_ff, state_in;

   logic [8:0]        face_count_ff;
   logic [6:0]        comp_count_ff;
   logic [FACE_W-1:0] face_ff, face_in, last_face;
   logic [COMP_W-1:0] comp_ff, comp_in, last_comp;
   logic [REF_AW-1:0] base_ff, base_in;
   logic [1:0]        drain_ff, drain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   nns_pkg::rsp_word_type rsp_word_ff;

   logic                  req_take, is_query_last, busy, start_scan;
   nns_pkg::store_we_type we;
   nns_pkg::scan_tag_type tag;
   logic [REF_AW-1:0]     ref_waddr, ref_raddr;
   logic [15:0]           ref_rdata, query_rdata;
   logic [7:0]            label_rdata;
   logic [FACE_W-1:0]     best_face;
   logic [nns_pkg::DIST_W-1:0] best_dist;

   always_comb begin
      if (face_count_ff == '0) begin
         last_face = '0;
      end else if (32'(face_count_ff) > MAX_FACES) begin
         last_face = FACE_W'(MAX_FACES - 1);
      end else begin
         last_face = FACE_W'(face_count_ff - 9'd1);
      end
      if (comp_count_ff == '0) begin
         last_comp = '0;
      end else if (32'(comp_count_ff) > MAX_COMPONENTS) begin
         last_comp = COMP_W'(MAX_COMPONENTS - 1);
      end else begin
         last_comp = COMP_W'(comp_count_ff - 7'd1);
      end
   end

   assign busy          = (state_ff != nns_pkg::ST_IDLE);
   assign is_query_last = (req_word.cmd == nns_pkg::CMD_QUERY) && req_word.query_last;
   assign req_stall     = busy || (rsp_valid_ff && req_valid && is_query_last);
   assign req_take      = req_valid && !req_stall;
   assign start_scan    = req_take && is_query_last;

   always_comb begin
      we.ref_we   = req_take && (req_word.cmd == nns_pkg::CMD_LOAD_REF) &&
                    (32'(req_word.face_index) < MAX_FACES) &&
                    (32'(req_word.component_index) < MAX_COMPONENTS);
      we.label_we = req_take && (req_word.cmd == nns_pkg::CMD_LOAD_LABEL) &&
                    (32'(req_word.face_index) < MAX_FACES);
      we.query_we = req_take && (req_word.cmd == nns_pkg::CMD_QUERY) &&
                    (32'(req_word.component_index) < MAX_COMPONENTS);
      ref_waddr   = REF_AW'(REF_AW'(req_word.face_index) * REF_AW'(MAX_COMPONENTS) +
                    REF_AW'(req_word.component_index));
   end

   always_comb begin
      state_in     = state_ff;
      face_in      = face_ff;
      comp_in      = comp_ff;
      base_in      = base_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tag          = '0;
      case (state_ff)
         nns_pkg::ST_IDLE: begin
            face_in = '0;
            comp_in = '0;
            base_in = '0;
            if (start_scan) begin
               state_in = nns_pkg::ST_SCAN;
            end
         end
         nns_pkg::ST_SCAN: begin
            tag.valid      = 1'b1;
            tag.first_comp = (comp_ff == '0);
            tag.last_comp  = (comp_ff == last_comp);
            tag.first_face = (face_ff == '0);
            if (comp_ff == last_comp) begin
               comp_in = '0;
               face_in = FACE_W'(face_ff + 1'b1);
               base_in = REF_AW'(base_ff + REF_AW'(MAX_COMPONENTS));
               if (face_ff == last_face) begin
                  drain_in = '0;
                  state_in = nns_pkg::ST_DRAIN;
               end
            end else begin
               comp_in = COMP_W'(comp_ff + 1'b1);
            end
         end
         nns_pkg::ST_DRAIN: begin
            drain_in = 2'(drain_ff + 2'd1);
            if (drain_ff == 2'd2) begin
               state_in = nns_pkg::ST_LABEL;
            end
         end
         nns_pkg::ST_LABEL: begin
            state_in = nns_pkg::ST_RESULT;
         end
         nns_pkg::ST_RESULT: begin
            rsp_valid_in = 1'b1;
            state_in     = nns_pkg::ST_IDLE;
         end
         default: begin
            state_in = nns_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nns_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         face_count_ff <= 9'd1;
         comp_count_ff <= 7'd1;
         face_ff       <= '0;
         comp_ff       <= '0;
         base_ff       <= '0;
         drain_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         face_ff      <= face_in;
         comp_ff      <= comp_in;
         base_ff      <= base_in;
         drain_ff     <= drain_in;
         if (csr_write) begin
            case (csr_index)
               nns_pkg::CSR_FACE_COUNT: face_count_ff <= csr_wdata;
               nns_pkg::CSR_COMP_COUNT: comp_count_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == nns_pkg::ST_RESULT) begin
         rsp_word_ff.nearest_index <= 8'(best_face);
         rsp_word_ff.nearest_label <= label_rdata;
         rsp_word_ff.best_distance <= best_dist;
      end
   end

   assign ref_raddr = REF_AW'(base_ff + REF_AW'(comp_ff));

   nns_store #(
      .FACE_W (FACE_W),
      .COMP_W (COMP_W),
      .REF_AW (REF_AW)
   ) u_store (
      .clock       (clock),
      .we          (we),
      .ref_waddr   (ref_waddr),
      .query_waddr (COMP_W'(req_word.component_index)),
      .label_waddr (FACE_W'(req_word.face_index)),
      .coeff_wdata (req_word.coeff_value),
      .label_wdata (req_word.label_value),
      .ref_raddr   (ref_raddr),
      .query_raddr (comp_ff),
      .label_raddr (best_face),
      .ref_rdata   (ref_rdata),
      .query_rdata (query_rdata),
      .label_rdata (label_rdata)
   );

   nns_dist #(
      .FACE_W (FACE_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .tag         (tag),
      .face        (face_ff),
      .ref_rdata   (ref_rdata),
      .query_rdata (query_rdata),
      .best_face   (best_face),
      .best_dist   (best_dist)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_take)
      else $error("request word taken during a scan");

   a_result_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == nns_pkg::ST_RESULT))
      else $error("result word raised outside the result step");

   a_scan_needs_empty_output: assert property (@(posedge clock) disable iff (reset)
      start_scan |-> !rsp_valid_ff)
      else $error("scan started while a result word is pending");
`endif

endmodule
